// ----- hw/rtl/hef_pkg.sv -----
// shared constants and types of the heat envelope follower
`default_nettype none
package hef_pkg;

  localparam int Q_W        = 16;
  localparam int ID_W       = 32;
  localparam int E_W        = 10;
  localparam int EC_W       = 8;
  localparam int SINCE_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_N_W    = EC_W + Q_W;
  localparam int DIV_D_W    = Q_W;
  localparam int DIV_CNT_W  = 5;

  localparam logic [EC_W-1:0]    ELAPSED_CLAMP = 8'd250;
  localparam logic [Q_W-1:0]     MIN_TIME      = 16'd10;
  localparam logic [Q_W-1:0]     Q_MAX         = 16'hFFFF;
  localparam logic [SINCE_W-1:0] SINCE_MAX     = 20'hFFFFF;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DIV_N_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FADE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FADE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_CAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_SW    = 3'd6;

  localparam logic [Q_W-1:0]     RST_MIN_FADE  = 16'd2000;
  localparam logic [Q_W-1:0]     RST_MAX_FADE  = 16'd13400;
  localparam logic [Q_W-1:0]     RST_RAMP_UP   = 16'd500;
  localparam logic [Q_W-1:0]     RST_RAMP_DOWN = 16'd1000;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hef_if.sv -----
// item channel interfaces of the heat envelope follower
`default_nettype none
interface hef_in_if import hef_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [E_W-1:0]  elapsed_ms;
  logic [Q_W-1:0]  shot_heat;
  logic [ID_W-1:0] weapon_id;

  modport source (output valid, action, elapsed_ms, shot_heat, weapon_id, input ready);
  modport sink (input valid, action, elapsed_ms, shot_heat, weapon_id, output ready);
endinterface

interface hef_out_if import hef_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] heat_level;
  logic [Q_W-1:0] visible_level;
  logic           alive;

  modport source (output valid, heat_level, visible_level, alive, input ready);
  modport sink (input valid, heat_level, visible_level, alive, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/heat_envelope_follower_top.sv -----
// heat envelope follower: heat, peak and visible level sequencer
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | action, elapsed_ms, shot_heat, weapon_id
//  out_ch   | out | valid/ready      | heat_level, visible_level, alive
//  cfg_*    | in  | cfg_we, no wait  | cfg_index, cfg_wdata
//
// a shot item skips the divider; a tick item makes two
// passes through the shared 24-step serial divider (fade decay, then slew step)
// in_ch.ready is high only while the sequencer is idle
// the result sits in an output register; a full register stalls the last step
// synchronous active-low reset loads register defaults, clears sequencer state
`default_nettype none
module heat_envelope_follower_top import hef_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hef_in_if.sink                     in_ch,
  hef_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DEC_GO   = 3'd2;
  localparam logic [2:0] S_DEC_WAIT = 3'd3;
  localparam logic [2:0] S_TGT      = 3'd4;
  localparam logic [2:0] S_STP_WAIT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [Q_W-1:0]     min_fade_r, max_fade_r, show_thr_r, ramp_up_r, ramp_down_r;
  logic [SINCE_W-1:0] dur_cap_r;
  logic               rst_sw_r;

  logic [2:0]         state_r, state_nxt;
  logic [Q_W-1:0]     heat_r, heat_nxt;
  logic [Q_W-1:0]     peak_r, peak_nxt;
  logic [Q_W-1:0]     vis_r, vis_nxt;
  logic [ID_W-1:0]    last_id_r, last_id_nxt;
  logic               seen_r, seen_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic [EC_W-1:0]    e_r, e_nxt;
  logic [2*Q_W-1:0]   prod_r, prod_nxt;
  logic [Q_W-1:0]     tgt_r, tgt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [Q_W-1:0]     out_heat_r, out_heat_nxt;
  logic [Q_W-1:0]     out_vis_r, out_vis_nxt;
  logic               out_alive_r, out_alive_nxt;

  div_req_t           dreq;
  div_rsp_t           drsp;

  logic               fade_up;
  logic [Q_W-1:0]     fade_diff, fade_raw, fade;
  logic [Q_W-1:0]     shot_base;
  logic [Q_W:0]       shot_sum;
  logic [Q_W-1:0]     shot_heat_v;
  logic [SINCE_W:0]   since_sum;
  logic [Q_W-1:0]     tgt_c, ramp_raw, ramp;
  logic [Q_W-1:0]     vis_gap;
  logic               accept;

  hef_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign accept = in_ch.valid && in_ch.ready;

  assign fade_up   = max_fade_r >= min_fade_r;
  assign fade_diff = fade_up ? max_fade_r - min_fade_r : min_fade_r - max_fade_r;
  assign fade_raw  = fade_up ? min_fade_r + prod_r[2*Q_W-1:Q_W]
                             : min_fade_r - prod_r[2*Q_W-1:Q_W];
  assign fade      = (fade_raw < MIN_TIME) ? MIN_TIME : fade_raw;

  assign shot_base   = (rst_sw_r && last_id_r != '0 && last_id_r != in_ch.weapon_id)
                       ? '0 : heat_r;
  assign shot_sum    = {1'b0, shot_base} + {1'b0, in_ch.shot_heat};
  assign shot_heat_v = shot_sum[Q_W] ? Q_MAX : shot_sum[Q_W-1:0];

  assign since_sum = {1'b0, since_r} + {{(SINCE_W+1-EC_W){1'b0}}, e_r};

  always_comb begin
    tgt_c = heat_r;
    if (heat_r < show_thr_r) tgt_c = '0;
    if (dur_cap_r != '0 && seen_r && since_r > dur_cap_r) tgt_c = '0;
  end

  assign ramp_raw = (tgt_c > vis_r) ? ramp_up_r : ramp_down_r;
  assign ramp     = (ramp_raw < MIN_TIME) ? MIN_TIME : ramp_raw;
  assign vis_gap  = (vis_r < tgt_r) ? tgt_r - vis_r : vis_r - tgt_r;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = {e_r, {Q_W{1'b0}}};
    dreq.divisor  = fade;
    unique case (state_r)
      S_DEC_GO: dreq.start = 1'b1;
      S_TGT: begin
        dreq.start   = 1'b1;
        dreq.divisor = ramp;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    heat_nxt      = heat_r;
    peak_nxt      = peak_r;
    vis_nxt       = vis_r;
    last_id_nxt   = last_id_r;
    seen_nxt      = seen_r;
    since_nxt     = since_r;
    e_nxt         = e_r;
    prod_nxt      = prod_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_heat_nxt  = out_heat_r;
    out_vis_nxt   = out_vis_r;
    out_alive_nxt = out_alive_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.action) begin
            last_id_nxt = in_ch.weapon_id;
            heat_nxt    = shot_heat_v;
            if (shot_base != heat_r || (rst_sw_r && last_id_r != '0 &&
                                        last_id_r != in_ch.weapon_id))
              peak_nxt = shot_heat_v;
            else if (shot_heat_v > peak_r)
              peak_nxt = shot_heat_v;
            else
              peak_nxt = peak_r;
            since_nxt = '0;
            seen_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            e_nxt     = (in_ch.elapsed_ms > {{(E_W-EC_W){1'b0}}, ELAPSED_CLAMP})
                        ? ELAPSED_CLAMP : in_ch.elapsed_ms[EC_W-1:0];
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = fade_diff * peak_r;
        since_nxt = since_sum[SINCE_W] ? SINCE_MAX : since_sum[SINCE_W-1:0];
        state_nxt = S_DEC_GO;
      end
      S_DEC_GO: state_nxt = S_DEC_WAIT;
      S_DEC_WAIT: begin
        if (drsp.done) begin
          heat_nxt  = ({{(DIV_N_W-Q_W){1'b0}}, heat_r} > drsp.quotient)
                      ? heat_r - drsp.quotient[Q_W-1:0] : '0;
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        tgt_nxt   = tgt_c;
        state_nxt = S_STP_WAIT;
      end
      S_STP_WAIT: begin
        if (drsp.done) begin
          if (vis_r != tgt_r) begin
            if ({{(DIV_N_W-Q_W){1'b0}}, vis_gap} > drsp.quotient)
              vis_nxt = (vis_r < tgt_r) ? vis_r + drsp.quotient[Q_W-1:0]
                                        : vis_r - drsp.quotient[Q_W-1:0];
            else
              vis_nxt = tgt_r;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_heat_nxt  = heat_r;
          out_vis_nxt   = vis_r;
          out_alive_nxt = (heat_r != '0) || (vis_r != '0);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_fade_r  <= RST_MIN_FADE;
      max_fade_r  <= RST_MAX_FADE;
      show_thr_r  <= '0;
      dur_cap_r   <= '0;
      ramp_up_r   <= RST_RAMP_UP;
      ramp_down_r <= RST_RAMP_DOWN;
      rst_sw_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_FADE:  min_fade_r  <= cfg_wdata[Q_W-1:0];
        CFG_MAX_FADE:  max_fade_r  <= cfg_wdata[Q_W-1:0];
        CFG_SHOW_THR:  show_thr_r  <= cfg_wdata[Q_W-1:0];
        CFG_DUR_CAP:   dur_cap_r   <= cfg_wdata[SINCE_W-1:0];
        CFG_RAMP_UP:   ramp_up_r   <= cfg_wdata[Q_W-1:0];
        CFG_RAMP_DOWN: ramp_down_r <= cfg_wdata[Q_W-1:0];
        CFG_RST_SW:    rst_sw_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heat_r      <= '0;
      peak_r      <= '0;
      vis_r       <= '0;
      last_id_r   <= '0;
      seen_r      <= 1'b0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heat_r      <= heat_nxt;
      peak_r      <= peak_nxt;
      vis_r       <= vis_nxt;
      last_id_r   <= last_id_nxt;
      seen_r      <= seen_nxt;
      since_r     <= since_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r         <= e_nxt;
    prod_r      <= prod_nxt;
    tgt_r       <= tgt_nxt;
    out_heat_r  <= out_heat_nxt;
    out_vis_r   <= out_vis_nxt;
    out_alive_r <= out_alive_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.heat_level    = out_heat_r;
  assign out_ch.visible_level = out_vis_r;
  assign out_ch.alive         = out_alive_r;

endmodule
`default_nettype wire

// ----- hw/rtl/hef_div.sv -----
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module hef_div import hef_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W:0]     rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_D_W:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r[DIV_D_W-1:0], quo_r[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire
